// ===== design/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Types and constants of the linear probing hash table; its channel
// interfaces declare their widths on their own.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int unsigned KEY_W        = 31;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned SLOT_FIELD_W = 7;

  // remainder unit: key times a rounded-up reciprocal of the slot count
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned PROD_W  = KEY_W + RECIP_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_FULL    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE
  } state_e;

  typedef struct packed {
    mark_e              mark;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

// ===== design/lph_if.sv =====
// ----------------------------------------------------------------------------
// lph_if
// Valid/ready channels of the hash table: request channel and result channel.
// ----------------------------------------------------------------------------
interface lph_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic        [30:0] key;
  logic signed [31:0] value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lph_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] read_value;
  logic        [6:0]  slot_used;

  modport source (output valid, output status, output read_value, output slot_used,
                  input ready);
  modport sink   (input valid, input status, input read_value, input slot_used,
                  output ready);
endinterface

// ===== design/linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open addressing hash table with linear probing over SLOTS slots held in one
// synchronous memory (mark, key and value per slot). After reset a clearing
// pass writes every slot empty; no request item is accepted while it runs.
// A request is accepted in S_IDLE and then walks the slots (1 to SLOTS
// visited), the single memory read port stepping one slot a cycle; when SLOTS
// is not a power of two the home slot first comes from a remainder unit
// (state S_MOD). Requests are handled one at a time; the result sits in an
// output register, so a new request is taken while the previous result still
// waits on the result channel.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
  import lph_pkg::*;
#(
  parameter int unsigned SLOTS = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lph_req_if.sink   req_i,
  lph_rsp_if.source rsp_o
);

  localparam int unsigned AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam bit          IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
  // quotient sits in the product bits from RSH upwards
  localparam int unsigned   RSH   = KEY_W + AW;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  // slot memory
  entry_t        mem [SLOTS];
  entry_t        rd_entry_q;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  // control and request registers
  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_idx_q, clr_idx_d;
  action_e                act_q, act_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [VALUE_W-1:0]     val_q, val_d;
  logic [AW-1:0]          home_q, home_d;
  logic [AW-1:0]          rd_idx_q;
  logic [AW-1:0]          probe_cnt_q, probe_cnt_d;
  logic                   has_tomb_q, has_tomb_d;
  logic [AW-1:0]          tomb_q, tomb_d;
  logic [PROD_W-1:0]      prod_q, prod_d;

  // result register
  logic                    rsp_valid_q;
  status_e                 rsp_status_q, rsp_status_d;
  logic [VALUE_W-1:0]      rsp_value_q, rsp_value_d;
  logic [AW-1:0]           rsp_slot_q, rsp_slot_d;
  logic                    rsp_load;
  logic                    out_free;

  // probe decode
  logic          is_hit, is_empty, is_tomb, is_last;
  logic          eff_has_tomb;
  logic [AW-1:0] eff_tomb;
  logic [AW-1:0] next_idx;

  // remainder step
  logic [PROD_W-RSH-1:0] mod_quot;
  logic [KEY_W-1:0]      mod_rem;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  assign is_hit       = (rd_entry_q.mark == MARK_FULL) && (rd_entry_q.key == key_q);
  assign is_empty     = (rd_entry_q.mark == MARK_EMPTY);
  assign is_tomb      = (rd_entry_q.mark != MARK_EMPTY) && (rd_entry_q.mark != MARK_FULL);
  assign is_last      = (probe_cnt_q == LAST_SLOT);
  assign eff_has_tomb = has_tomb_q || is_tomb;
  assign eff_tomb     = has_tomb_q ? tomb_q : rd_idx_q;
  assign next_idx     = (rd_idx_q == LAST_SLOT) ? '0 : rd_idx_q + 1'b1;

  // exact quotient from the registered product, then key minus quotient times slots
  assign mod_quot = prod_q[PROD_W-1:RSH];
  assign mod_rem  = key_q - KEY_W'(mod_quot) * KEY_W'(SLOTS);

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    act_d        = act_q;
    key_d        = key_q;
    val_d        = val_q;
    home_d       = home_q;
    probe_cnt_d  = probe_cnt_q;
    has_tomb_d   = has_tomb_q;
    tomb_d       = tomb_q;
    prod_d       = prod_q;
    mem_raddr    = rd_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_q;
    mem_wdata    = rd_entry_q;
    rsp_load     = 1'b0;
    rsp_status_d = ST_NOT_FOUND;
    rsp_value_d  = '0;
    rsp_slot_d   = home_q;
    req_i.ready  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = clr_idx_q;
        mem_wdata      = '0;
        mem_wdata.mark = MARK_EMPTY;
        if (clr_idx_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end

      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          act_d       = action_e'(req_i.action);
          key_d       = req_i.key;
          val_d       = req_i.value;
          probe_cnt_d = '0;
          has_tomb_d  = 1'b0;
          if (IS_POW2) begin
            home_d    = AW'(req_i.key);
            mem_raddr = AW'(req_i.key);
            state_d   = S_PROBE;
          end else begin
            prod_d  = PROD_W'(req_i.key) * PROD_W'(RECIP);
            state_d = S_MOD;
          end
        end
      end

      S_MOD: begin
        home_d    = mod_rem[AW-1:0];
        mem_raddr = mod_rem[AW-1:0];
        state_d   = S_PROBE;
      end

      S_PROBE: begin
        if (!(is_hit || is_empty || is_last)) begin
          if (is_tomb && !has_tomb_q) begin
            has_tomb_d = 1'b1;
            tomb_d     = rd_idx_q;
          end
          probe_cnt_d = probe_cnt_q + 1'b1;
          mem_raddr   = next_idx;
        end else if (out_free) begin
          // walk over: settle the item and write back at most one slot
          rsp_load = 1'b1;
          state_d  = S_IDLE;
          case (act_q)
            ACT_INSERT: begin
              mem_wdata.mark  = MARK_FULL;
              mem_wdata.key   = key_q;
              mem_wdata.value = val_q;
              if (is_hit) begin
                mem_we       = 1'b1;
                mem_waddr    = rd_idx_q;
                rsp_status_d = ST_OK;
                rsp_slot_d   = rd_idx_q;
              end else if (eff_has_tomb) begin
                mem_we       = 1'b1;
                mem_waddr    = eff_tomb;
                rsp_status_d = ST_OK;
                rsp_slot_d   = eff_tomb;
              end else if (is_empty) begin
                mem_we       = 1'b1;
                mem_waddr    = rd_idx_q;
                rsp_status_d = ST_OK;
                rsp_slot_d   = rd_idx_q;
              end else begin
                rsp_status_d = ST_FULL;
              end
            end
            ACT_REMOVE: begin
              if (is_hit) begin
                mem_we         = 1'b1;
                mem_waddr      = rd_idx_q;
                mem_wdata.mark = MARK_DELETED;
                rsp_status_d   = ST_OK;
                rsp_slot_d     = rd_idx_q;
              end
            end
            default: begin
              // search, and the unused action code behaves as search
              if (is_hit) begin
                rsp_status_d = ST_OK;
                rsp_value_d  = rd_entry_q.value;
                rsp_slot_d   = rd_idx_q;
              end
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry_q <= mem[mem_raddr];
    rd_idx_q   <= mem_raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    key_q       <= key_d;
    val_q       <= val_d;
    home_q      <= home_d;
    probe_cnt_q <= probe_cnt_d;
    has_tomb_q  <= has_tomb_d;
    tomb_q      <= tomb_d;
    prod_q      <= prod_d;
    if (rsp_load) begin
      rsp_status_q <= rsp_status_d;
      rsp_value_q  <= rsp_value_d;
      rsp_slot_q   <= rsp_slot_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.read_value = rsp_value_q;
  assign rsp_o.slot_used  = SLOT_FIELD_W'(rsp_slot_q);

`ifndef SYNTH
  // no request item while the clearing pass runs
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_i.ready)
    else $error("request accepted during clearing pass");

  // a write during the walk always ends the item
  a_write_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_PROBE) |=> (state_q == S_IDLE))
    else $error("slot written without finishing the item");

  // a new result only comes out of a probe walk
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == S_PROBE))
    else $error("result raised outside the probe walk");

  // a non-zero value is only returned by a successful lookup
  a_value_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_value_q != '0) |-> (rsp_status_q == ST_OK))
    else $error("value returned with a miss status");
`endif

endmodule
